### design/jgtb_pkg.sv
package jgtb_pkg;

  typedef logic signed [31:0] word_t;

  localparam int TpW = 35;
  typedef logic signed [TpW-1:0] tprod_t;

  typedef struct packed {
    logic [1:0] c;
    logic [1:0] r;
    logic [1:0] k;
  } mcnt_t;

  function automatic word_t sat32(input logic signed [67:0] v);
    word_t res;
    if (v > 68'sd2147483647) begin
      res = 32'sh7fffffff;
    end else if (v < -68'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  function automatic mcnt_t mcnt_step(input mcnt_t m);
    mcnt_t n;
    n = m;
    if (m.k == 2'd2) begin
      n.k = 2'd0;
      if (m.r == 2'd2) begin
        n.r = 2'd0;
        n.c = m.c + 2'd1;
      end else begin
        n.r = m.r + 2'd1;
      end
    end else begin
      n.k = m.k + 2'd1;
    end
    return n;
  endfunction

endpackage

### design/jgtb_ram.sv
module jgtb_ram #(
  parameter int Width = 96,
  parameter int Depth = 1024,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/joint_global_transform_builder_unit.sv
// One joint per request, parents before children. A root joint has a negative parent, or a
// parent index not below the joint's own number, which also raises parent_error. A single
// shared 32x32 multiplier forms 9 quaternion products and 9 scale products for every joint
// and, for a child, 36 parent-times-local products after the parent's four columns are read
// from the matrix memory. Each joint's global matrix is written, one column per result, into
// a memory of MAX_JOINTS x 4 columns; entries are not cleared at reset and hold data only once
// written. A new request is taken once all four column results of the previous one are out.
module joint_global_transform_builder_unit import jgtb_pkg::*; #(
  parameter int MAX_JOINTS = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] trans_x_i,
  input  logic signed [31:0] trans_y_i,
  input  logic signed [31:0] trans_z_i,
  input  logic signed [31:0] quat_x_i,
  input  logic signed [31:0] quat_y_i,
  input  logic signed [31:0] quat_z_i,
  input  logic signed [31:0] quat_w_i,
  input  logic signed [31:0] scale_x_i,
  input  logic signed [31:0] scale_y_i,
  input  logic signed [31:0] scale_z_i,
  input  logic signed [8:0]  parent_index_i,
  input  logic               last_joint_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         joint_number_o,
  output logic [1:0]         column_number_o,
  output logic signed [31:0] row0_value_o,
  output logic signed [31:0] row1_value_o,
  output logic signed [31:0] row2_value_o,
  output logic               parent_error_o,
  output logic               last_column_o
);

  localparam int CW = $clog2(MAX_JOINTS + 1);
  localparam int Depth = MAX_JOINTS * 4;
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StQmul  = 3'd1;
  localparam logic [2:0] StRot   = 3'd2;
  localparam logic [2:0] StSmul  = 3'd3;
  localparam logic [2:0] StPread = 3'd4;
  localparam logic [2:0] StGmul  = 3'd5;
  localparam logic [2:0] StFirst = 3'd6;
  localparam logic [2:0] StOut   = 3'd7;

  logic [2:0]    state_q, state_d;
  mcnt_t         cnt_q, cnt_d, tag_q;
  logic          drain_q, drain_d;
  logic          mvld_q, mvld_d;
  logic [1:0]    ocol_q, ocol_d;
  logic [CW-1:0] jcnt_q, jcnt_d;
  logic          ovld_q, ovld_d;
  logic          issue, load, last_issue;
  logic [1:0]    lcol;

  word_t         q_q [4];
  word_t         s_q [3];
  word_t         t_q [3];
  logic [7:0]    pidx_q;
  logic          has_parent_q, perr_q;
  logic [CW-1:0] j_q;
  tprod_t        tp_q [3][3];
  word_t         rot_q [3][3];
  word_t         loc_q [3][3];
  word_t         par_q [4][3];
  word_t         glob_q [3][4];
  logic signed [65:0] acc_q;
  logic signed [63:0] prod_q;

  word_t         mul_a, mul_b;
  logic [1:0]    qa, qb;
  logic          acc_has, acc_err;
  logic [31:0]   pu;
  logic [31:0]   raddr_w, waddr_w;
  logic          we;
  logic [95:0]   rdata, wdata;
  word_t         col_v [3];

  logic [7:0]    jn_q;
  logic [1:0]    cn_q;
  word_t         r0_q, r1_q, r2_q;
  logic          pe_q, lc_q;

  assign in_ready_o = (state_q == StIdle);
  assign last_issue = (cnt_q.r == 2'd2) && (cnt_q.k == 2'd2)
                      && ((state_q != StGmul) || (cnt_q.c == 2'd3));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    drain_d = drain_q;
    mvld_d  = 1'b0;
    ocol_d  = ocol_q;
    jcnt_d  = jcnt_q;
    ovld_d  = ovld_q;
    issue   = 1'b0;
    load    = 1'b0;
    lcol    = ocol_q + 2'd1;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StQmul;
          cnt_d   = '0;
          drain_d = 1'b0;
          if (last_joint_i) begin
            jcnt_d = '0;
          end else if (32'(jcnt_q) < MAX_JOINTS) begin
            jcnt_d = jcnt_q + CW'(1);
          end
        end
      end
      StQmul, StSmul, StGmul: begin
        if (drain_q) begin
          drain_d = 1'b0;
          cnt_d   = '0;
          if (state_q == StQmul) begin
            state_d = StRot;
          end else if (state_q == StSmul) begin
            state_d = has_parent_q ? StPread : StFirst;
          end else begin
            state_d = StFirst;
          end
        end else begin
          issue  = 1'b1;
          mvld_d = 1'b1;
          if (last_issue) begin
            drain_d = 1'b1;
          end else begin
            cnt_d = mcnt_step(cnt_q);
          end
        end
      end
      StRot: begin
        state_d = StSmul;
      end
      StPread: begin
        if (drain_q) begin
          drain_d = 1'b0;
          cnt_d   = '0;
          state_d = StGmul;
        end else begin
          issue  = 1'b1;
          mvld_d = 1'b1;
          if (cnt_q.c == 2'd3) begin
            drain_d = 1'b1;
          end else begin
            cnt_d.c = cnt_q.c + 2'd1;
          end
        end
      end
      StFirst: begin
        lcol    = 2'd0;
        load    = 1'b1;
        ovld_d  = 1'b1;
        ocol_d  = 2'd0;
        state_d = StOut;
      end
      StOut: begin
        if (out_ready_i) begin
          if (ocol_q == 2'd3) begin
            ovld_d  = 1'b0;
            state_d = StIdle;
          end else begin
            load   = 1'b1;
            ocol_d = ocol_q + 2'd1;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      drain_q <= 1'b0;
      mvld_q  <= 1'b0;
      ocol_q  <= '0;
      jcnt_q  <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      drain_q <= drain_d;
      mvld_q  <= mvld_d;
      ocol_q  <= ocol_d;
      jcnt_q  <= jcnt_d;
      ovld_q  <= ovld_d;
    end
  end

  // parent check against the joint number at request time
  assign pu      = 32'(parent_index_i[7:0]);
  assign acc_has = !parent_index_i[8] && (pu < 32'(jcnt_q)) && (pu < MAX_JOINTS);
  assign acc_err = !parent_index_i[8] && !acc_has;

  always_comb begin
    unique case (cnt_q.r)
      2'd0: begin
        qa = cnt_q.k;
        qb = cnt_q.k;
      end
      2'd1: begin
        qa = (cnt_q.k == 2'd2) ? 2'd1 : 2'd0;
        qb = (cnt_q.k == 2'd0) ? 2'd1 : 2'd2;
      end
      default: begin
        qa = 2'd3;
        qb = cnt_q.k;
      end
    endcase
  end

  always_comb begin
    mul_a = q_q[qa];
    mul_b = q_q[qb];
    if (state_q == StSmul) begin
      mul_a = rot_q[cnt_q.r][cnt_q.k];
      mul_b = s_q[cnt_q.k];
    end else if (state_q == StGmul) begin
      mul_a = par_q[cnt_q.k][cnt_q.r];
      mul_b = (cnt_q.c == 2'd3) ? t_q[cnt_q.k] : loc_q[cnt_q.k][cnt_q.c];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (issue) begin
      tag_q <= cnt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      t_q[0] <= trans_x_i;
      t_q[1] <= trans_y_i;
      t_q[2] <= trans_z_i;
      q_q[0] <= quat_x_i;
      q_q[1] <= quat_y_i;
      q_q[2] <= quat_z_i;
      q_q[3] <= quat_w_i;
      s_q[0] <= scale_x_i;
      s_q[1] <= scale_y_i;
      s_q[2] <= scale_z_i;
      pidx_q <= parent_index_i[7:0];
      has_parent_q <= acc_has;
      perr_q <= acc_err;
      j_q <= jcnt_q;
    end
  end

  // product consumers
  logic signed [63:0] qround, sround;
  logic signed [65:0] pext, gsum, gval;
  logic signed [36:0] one, xx, yy, zz, xy, xz, yz, wx, wy, wz;

  assign qround = (prod_q + (64'sd1 <<< 28)) >>> 29;
  assign sround = (prod_q + (64'sd1 <<< 29)) >>> 30;
  assign pext   = 66'(prod_q);
  assign gsum   = (acc_q + pext) >>> 16;
  assign gval   = gsum + ((tag_q.c == 2'd3) ? 66'(par_q[3][tag_q.r]) : 66'sd0);

  assign one = 37'sd1 <<< 30;
  assign xx  = 37'(tp_q[0][0]);
  assign yy  = 37'(tp_q[0][1]);
  assign zz  = 37'(tp_q[0][2]);
  assign xy  = 37'(tp_q[1][0]);
  assign xz  = 37'(tp_q[1][1]);
  assign yz  = 37'(tp_q[1][2]);
  assign wx  = 37'(tp_q[2][0]);
  assign wy  = 37'(tp_q[2][1]);
  assign wz  = 37'(tp_q[2][2]);

  always_ff @(posedge clk_i) begin
    if (mvld_q) begin
      unique case (state_q)
        StQmul: tp_q[tag_q.r][tag_q.k] <= qround[TpW-1:0];
        StSmul: loc_q[tag_q.r][tag_q.k] <= sat32(68'(sround));
        StPread: begin
          par_q[tag_q.c][0] <= rdata[31:0];
          par_q[tag_q.c][1] <= rdata[63:32];
          par_q[tag_q.c][2] <= rdata[95:64];
        end
        StGmul: begin
          unique case (tag_q.k)
            2'd0:    acc_q <= pext + 66'sd32768;
            2'd1:    acc_q <= acc_q + pext;
            default: glob_q[tag_q.r][tag_q.c] <= sat32(68'(gval));
          endcase
        end
        default: acc_q <= acc_q;
      endcase
    end
    if (state_q == StRot) begin
      rot_q[0][0] <= sat32(68'(one - (yy + zz)));
      rot_q[1][0] <= sat32(68'(xy + wz));
      rot_q[2][0] <= sat32(68'(xz - wy));
      rot_q[0][1] <= sat32(68'(xy - wz));
      rot_q[1][1] <= sat32(68'(one - (xx + zz)));
      rot_q[2][1] <= sat32(68'(yz + wx));
      rot_q[0][2] <= sat32(68'(xz + wy));
      rot_q[1][2] <= sat32(68'(yz - wx));
      rot_q[2][2] <= sat32(68'(one - (xx + yy)));
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      if (has_parent_q) begin
        col_v[r] = glob_q[r][lcol];
      end else if (lcol == 2'd3) begin
        col_v[r] = t_q[r];
      end else begin
        col_v[r] = loc_q[r][lcol];
      end
    end
  end

  assign raddr_w = 32'(pidx_q) * 32'd4 + 32'(cnt_q.c);
  assign waddr_w = 32'(j_q) * 32'd4 + 32'(lcol);
  assign wdata   = {col_v[2], col_v[1], col_v[0]};
  assign we      = load && (32'(j_q) < MAX_JOINTS);

  jgtb_ram #(
    .Width(96),
    .Depth(Depth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr_w[AW-1:0]),
    .wdata_i(wdata),
    .raddr_i(raddr_w[AW-1:0]),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i) begin
    if (load) begin
      jn_q <= 8'(32'(j_q));
      cn_q <= lcol;
      r0_q <= col_v[0];
      r1_q <= col_v[1];
      r2_q <= col_v[2];
      pe_q <= perr_q;
      lc_q <= (lcol == 2'd3);
    end
  end

  assign out_valid_o     = ovld_q;
  assign joint_number_o  = jn_q;
  assign column_number_o = cn_q;
  assign row0_value_o    = r0_q;
  assign row1_value_o    = r1_q;
  assign row2_value_o    = r2_q;
  assign parent_error_o  = pe_q;
  assign last_column_o   = lc_q;

endmodule

### tb/jgtb_matrix_checker.sv
module jgtb_matrix_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [31:0] trans_x_i,
  input  logic signed [31:0] trans_y_i,
  input  logic signed [31:0] trans_z_i,
  input  logic signed [31:0] quat_x_i,
  input  logic signed [31:0] quat_y_i,
  input  logic signed [31:0] quat_z_i,
  input  logic signed [31:0] quat_w_i,
  input  logic signed [31:0] scale_x_i,
  input  logic signed [31:0] scale_y_i,
  input  logic signed [31:0] scale_z_i,
  input  logic signed [8:0]  parent_index_i,
  input  logic               last_joint_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [7:0]         joint_number_i,
  input  logic [1:0]         column_number_i,
  input  logic signed [31:0] row0_value_i,
  input  logic signed [31:0] row1_value_i,
  input  logic signed [31:0] row2_value_i,
  input  logic               parent_error_i,
  input  logic               last_column_i,
  output int                 fail_count_o,
  output int                 columns_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumJoints = 256;

  typedef struct {
    logic [7:0]         joint;
    logic [1:0]         col;
    logic signed [31:0] row [3];
    logic               perr;
    logic               lastc;
  } column_t;

  column_t     columns_due [$];
  longint      global_mat [NumJoints][4][3];
  int unsigned joint_idx;

  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic build_joint();
    longint q [4];
    longint t [3];
    longint s [3];
    longint xx, yy, zz, xy, xz, yz, wx, wy, wz, one, hi, v;
    longint rot [3][3];
    longint loc [3][4];
    longint glob [3][4];
    longint p;
    longint unsigned lo;
    int     parent;
    bit     has_parent, perr;
    column_t e;
    q = '{longint'(quat_x_i), longint'(quat_y_i), longint'(quat_z_i), longint'(quat_w_i)};
    t = '{longint'(trans_x_i), longint'(trans_y_i), longint'(trans_z_i)};
    s = '{longint'(scale_x_i), longint'(scale_y_i), longint'(scale_z_i)};
    parent = int'(parent_index_i);
    one = 64'sd1 << 30;
    xx = round_shift(q[0] * q[0], 29);
    yy = round_shift(q[1] * q[1], 29);
    zz = round_shift(q[2] * q[2], 29);
    xy = round_shift(q[0] * q[1], 29);
    xz = round_shift(q[0] * q[2], 29);
    yz = round_shift(q[1] * q[2], 29);
    wx = round_shift(q[3] * q[0], 29);
    wy = round_shift(q[3] * q[1], 29);
    wz = round_shift(q[3] * q[2], 29);
    rot[0][0] = one - (yy + zz); rot[1][0] = xy + wz; rot[2][0] = xz - wy;
    rot[0][1] = xy - wz; rot[1][1] = one - (xx + zz); rot[2][1] = yz + wx;
    rot[0][2] = xz + wy; rot[1][2] = yz - wx; rot[2][2] = one - (xx + yy);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        loc[r][c] = clamp32(round_shift(clamp32(rot[r][c]) * s[c], 30));
      end
      loc[r][3] = t[r];
    end
    has_parent = 1'b0;
    perr = 1'b0;
    if (parent >= 0) begin
      if (parent < joint_idx && parent < NumJoints) has_parent = 1'b1;
      else perr = 1'b1;
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 3; r++) begin
        if (has_parent) begin
          hi = 0;
          lo = 0;
          for (int k = 0; k < 3; k++) begin
            p = global_mat[parent][k][r] * loc[k][c];
            hi += p >>> 16;
            lo += longint'(p) & 64'hFFFF;
          end
          v = hi + longint'((lo + 64'h8000) >> 16);
          if (c == 3) v += global_mat[parent][3][r];
          glob[r][c] = clamp32(v);
        end else begin
          glob[r][c] = loc[r][c];
        end
      end
    end
    for (int c = 0; c < 4; c++) begin
      if (joint_idx < NumJoints) begin
        for (int r = 0; r < 3; r++) global_mat[joint_idx][c][r] = glob[r][c];
      end
      e.joint = joint_idx[7:0];
      e.col = c[1:0];
      for (int r = 0; r < 3; r++) e.row[r] = glob[r][c][31:0];
      e.perr = perr;
      e.lastc = (c == 3);
      columns_due.push_back(e);
    end
    if (last_joint_i) joint_idx = 0;
    else if (joint_idx < NumJoints) joint_idx++;
  endtask

  task automatic check_column();
    column_t e;
    if (columns_due.size() == 0) begin
      $display("%0t: unexpected column joint %0d col %0d", $time, joint_number_i,
               column_number_i);
      fail_count_o++;
      return;
    end
    e = columns_due.pop_front();
    if (e.joint !== joint_number_i || e.col !== column_number_i ||
        e.row[0] !== row0_value_i || e.row[1] !== row1_value_i ||
        e.row[2] !== row2_value_i || e.perr !== parent_error_i ||
        e.lastc !== last_column_i) begin
      $display("%0t: mismatch expected j%0d c%0d %h %h %h perr %b last %b", $time,
               e.joint, e.col, e.row[0], e.row[1], e.row[2], e.perr, e.lastc);
      $display("%0t:            actual j%0d c%0d %h %h %h perr %b last %b", $time,
               joint_number_i, column_number_i, row0_value_i, row1_value_i,
               row2_value_i, parent_error_i, last_column_i);
      fail_count_o++;
    end
  endtask

  initial begin
    fail_count_o = 0;
    joint_idx = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) build_joint();
      if (out_valid_i && out_ready_i) check_column();
    end
    columns_due_o = columns_due.size();
  end

endmodule

### tb/tb_joint_global_transform_builder_unit.sv
module tb_joint_global_transform_builder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 20000;
  localparam int RandomJoints = 310;

  logic               clk, rst_n;
  logic               in_valid, in_ready, out_valid, out_ready;
  logic signed [31:0] trans_x, trans_y, trans_z;
  logic signed [31:0] quat_x, quat_y, quat_z, quat_w;
  logic signed [31:0] scale_x, scale_y, scale_z;
  logic signed [8:0]  parent_index;
  logic               last_joint;
  logic [7:0]         joint_number;
  logic [1:0]         column_number;
  logic signed [31:0] row0_value, row1_value, row2_value;
  logic               parent_error, last_column;
  int                 fail_count, columns_due;
  int                 send_idle_pct, recv_stall_pct;
  int                 quiet_cycles;
  int unsigned        next_joint;

  joint_global_transform_builder_unit u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .trans_x_i(trans_x), .trans_y_i(trans_y), .trans_z_i(trans_z),
    .quat_x_i(quat_x), .quat_y_i(quat_y), .quat_z_i(quat_z), .quat_w_i(quat_w),
    .scale_x_i(scale_x), .scale_y_i(scale_y), .scale_z_i(scale_z),
    .parent_index_i(parent_index), .last_joint_i(last_joint),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .joint_number_o(joint_number), .column_number_o(column_number),
    .row0_value_o(row0_value), .row1_value_o(row1_value), .row2_value_o(row2_value),
    .parent_error_o(parent_error), .last_column_o(last_column)
  );

  jgtb_matrix_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .trans_x_i(trans_x), .trans_y_i(trans_y), .trans_z_i(trans_z),
    .quat_x_i(quat_x), .quat_y_i(quat_y), .quat_z_i(quat_z), .quat_w_i(quat_w),
    .scale_x_i(scale_x), .scale_y_i(scale_y), .scale_z_i(scale_z),
    .parent_index_i(parent_index), .last_joint_i(last_joint),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .joint_number_i(joint_number), .column_number_i(column_number),
    .row0_value_i(row0_value), .row1_value_i(row1_value), .row2_value_i(row2_value),
    .parent_error_i(parent_error), .last_column_i(last_column),
    .fail_count_o(fail_count), .columns_due_o(columns_due)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_joint(input logic signed [31:0] t [3], input logic signed [31:0] q [4],
                            input logic signed [31:0] s [3], input logic signed [8:0] parent,
                            input logic last);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid = 1'b1;
    trans_x = t[0]; trans_y = t[1]; trans_z = t[2];
    quat_x = q[0]; quat_y = q[1]; quat_z = q[2]; quat_w = q[3];
    scale_x = s[0]; scale_y = s[1]; scale_z = s[2];
    parent_index = parent;
    last_joint = last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
    if (last) next_joint = 0;
    else if (next_joint < 256) next_joint++;
  endtask

  function automatic logic signed [31:0] rand_word(int pct_full, int span);
    if ($urandom_range(99) < pct_full) return $urandom;
    return $signed($urandom_range(2 * span)) - span;
  endfunction

  task automatic send_random(input logic last);
    logic signed [31:0] t [3];
    logic signed [31:0] q [4];
    logic signed [31:0] s [3];
    logic signed [8:0]  parent;
    int                 pick;
    for (int i = 0; i < 3; i++) begin
      t[i] = rand_word(15, 32'h0040_0000);
      s[i] = ($urandom_range(99) < 15) ? $urandom : 32'sh1_0000 + rand_word(0, 32'h8000);
    end
    for (int i = 0; i < 4; i++) q[i] = rand_word(10, 32'h2000_0000);
    pick = $urandom_range(99);
    if (pick < 70 && next_joint > 0) parent = 9'($urandom_range(next_joint - 1));
    else if (pick < 85) parent = -9'sd1;
    else parent = 9'($urandom_range(511));
    send_joint(t, q, s, parent, last);
  endtask

  initial begin
    logic signed [31:0] id_q [4];
    logic signed [31:0] one_s [3];
    logic signed [31:0] zero_t [3];
    logic signed [31:0] max_t [3];
    logic signed [31:0] min_t [3];
    int sent, pass_len;
    in_valid = 1'b0;
    out_ready = 1'b0;
    trans_x = '0; trans_y = '0; trans_z = '0;
    quat_x = '0; quat_y = '0; quat_z = '0; quat_w = '0;
    scale_x = '0; scale_y = '0; scale_z = '0;
    parent_index = '0;
    last_joint = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    quiet_cycles = 0;
    next_joint = 0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    id_q = '{32'sd0, 32'sd0, 32'sd0, 32'sh4000_0000};
    one_s = '{32'sh1_0000, 32'sh1_0000, 32'sh1_0000};
    zero_t = '{32'sd0, 32'sd0, 32'sd0};
    max_t = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff};
    min_t = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
    // root, chain, saturating children, bad parents, pass end
    send_joint(zero_t, id_q, one_s, -9'sd1, 1'b0);
    send_joint(max_t, id_q, one_s, 9'sd0, 1'b0);
    send_joint(max_t, id_q, one_s, 9'sd1, 1'b0);
    send_joint(min_t, '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000},
               max_t, 9'sd2, 1'b0);
    send_joint(min_t, '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff},
               min_t, 9'sd3, 1'b0);
    send_joint(max_t, '{32'sh7fff_ffff, 32'sh8000_0000, 32'sd0, 32'sh7fff_ffff},
               max_t, 9'sd4, 1'b0);
    send_joint(zero_t, '{32'sh2d41_3ccd, 32'sd0, 32'sd0, 32'sh2d41_3ccd},
               '{32'sh2_0000, 32'sh8000, 32'shffff_0000}, 9'sd5, 1'b0);
    send_joint(zero_t, id_q, one_s, 9'sd7, 1'b0);
    send_joint(zero_t, id_q, one_s, 9'sd255, 1'b0);
    send_joint(zero_t, id_q, one_s, -9'sd256, 1'b0);
    send_joint(max_t, id_q, one_s, 9'sd6, 1'b1);
    send_joint(zero_t, id_q, one_s, 9'sd0, 1'b0);
    send_joint(min_t, id_q, one_s, 9'sd0, 1'b1);

    sent = 0;
    while (sent < RandomJoints) begin
      pass_len = (sent == 0) ? 262 : $urandom_range(1, 16);
      for (int i = 0; i < pass_len; i++) begin
        case ((sent * 4) / RandomJoints)
          0: begin send_idle_pct = 0; recv_stall_pct = 0; end
          1: begin send_idle_pct = 69; recv_stall_pct = 0; end
          2: begin send_idle_pct = 0; recv_stall_pct = 69; end
          default: begin send_idle_pct = 6; recv_stall_pct = 6; end
        endcase
        if ($urandom_range(99) < 5) begin
          send_idle_pct = 0; recv_stall_pct = 0;
        end
        send_random(i == pass_len - 1);
        sent++;
      end
    end

    while (columns_due != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
